### hdl/mi3_pkg.sv
package mi3_pkg;

	localparam int unsigned EW = 32;
	localparam int unsigned CW = 64;
	localparam int unsigned DW = 97;
	localparam int unsigned MW = 96;
	localparam int unsigned QW = 34;

	typedef struct packed {
		logic signed [EW-1:0] a00;
		logic signed [EW-1:0] a01;
		logic signed [EW-1:0] a02;
		logic signed [EW-1:0] a10;
		logic signed [EW-1:0] a11;
		logic signed [EW-1:0] a12;
		logic signed [EW-1:0] a20;
		logic signed [EW-1:0] a21;
		logic signed [EW-1:0] a22;
	} mat_in_t;

	typedef struct packed {
		logic signed [EW-1:0] b00;
		logic signed [EW-1:0] b01;
		logic signed [EW-1:0] b02;
		logic signed [EW-1:0] b10;
		logic signed [EW-1:0] b11;
		logic signed [EW-1:0] b12;
		logic signed [EW-1:0] b20;
		logic signed [EW-1:0] b21;
		logic signed [EW-1:0] b22;
		logic signed [63:0]   determinant;
		logic                 singular;
	} mat_out_t;

	typedef struct packed {
		logic [8:0][CW-1:0] cof;
		logic signed [DW-1:0] det;
	} job_t;

endpackage

### hdl/mi3_if.sv
interface mat_in_if;
	import mi3_pkg::*;
	logic    valid;
	logic    ready;
	mat_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mat_out_if;
	import mi3_pkg::*;
	logic     valid;
	logic     ready;
	mat_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/matrix3_inverse.sv
// Pipeline: 4 front stages (the first at the accept edge), the queue, 35 divider stages
// and 1 output register.
// Throughput: one matrix per cycle; output stalls freeze only the divider, and the input
// stalls only when the queue cannot take everything in the front pipe.
// Reset: arst_n clears all valid flags and queue pointers; data is not reset.
module matrix3_inverse import mi3_pkg::*; #(
	parameter int unsigned QDEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	mat_in_if.sink    in_ch,
	mat_out_if.source out_ch
);
	localparam int unsigned FILL = 5 + QW;
	logic f_vld, f_en, d_en, d_vld, q_empty, pop;
	job_t f_job, q_job;
	mat_out_t d_res;
	logic [$clog2(QDEPTH+1)-1:0] q_cnt;
	logic [$clog2(FILL+QDEPTH+2)-1:0] infl_q;
	logic ovld_q;
	mat_out_t o_q;

	// front always runs; input is taken only when the queue has room for everything in flight
	assign f_en = 1'b1;
	assign in_ch.ready = (32'(q_cnt) + 32'd5) <= QDEPTH;

	mi3_front u_front (.clk, .arst_n, .en(f_en), .in_vld(in_ch.valid && in_ch.ready),
		.m(in_ch.data), .out_vld(f_vld), .job(f_job));

	assign d_en = !ovld_q || out_ch.ready || !d_vld;
	assign pop = d_en && !q_empty;

	mi3_fifo #(.DEPTH(QDEPTH)) u_fifo (.clk, .arst_n, .wr(f_vld), .wdata(f_job),
		.rd(pop), .empty(q_empty), .count(q_cnt), .rdata(q_job));

	mi3_div u_div (.clk, .arst_n, .en(d_en), .in_vld(pop), .job(q_job),
		.out_vld(d_vld), .res(d_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (d_en) ovld_q <= d_vld || (ovld_q && !out_ch.ready);
	end

	always_ff @(posedge clk) begin
		if (d_en && d_vld) o_q <= d_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) infl_q <= '0;
		else infl_q <= infl_q + (in_ch.valid && in_ch.ready ? 1'b1 : 1'b0)
			- (ovld_q && out_ch.ready ? 1'b1 : 1'b0);
	end

	assign out_ch.valid = ovld_q;
	assign out_ch.data = o_q;

	a_nooverflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_vld && 32'(q_cnt) == QDEPTH && !pop)) else $error("queue overflow");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && o_q.singular |-> o_q.determinant == '0) else $error("singular det");
	a_out_infl: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q |-> infl_q != '0) else $error("output without item");
endmodule

### hdl/mi3_front.sv
// Cofactors and determinant in one pipe; en moves every stage.
module mi3_front import mi3_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_vld,
	input  mat_in_t m,
	output logic    out_vld,
	output job_t    job
);
	logic [3:0] v_q;
	logic signed [2*EW-1:0] p_s1 [18];
	logic signed [EW-1:0] r0_s1 [3];
	logic signed [CW-1:0] c_s2 [9];
	logic signed [EW-1:0] r0_s2 [3];
	logic signed [2*EW-1:0] ph_s3 [3];
	logic signed [2*EW:0] pl_s3 [3];
	logic signed [DW-1:0] t_s4 [3];
	logic [8:0][CW-1:0] c_s3;
	logic [8:0][CW-1:0] c_s4;
	logic signed [EW-1:0] x [9];

	assign x = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[2:0], in_vld};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= x[4]*x[8]; p_s1[1] <= x[5]*x[7];
			p_s1[2] <= x[5]*x[6]; p_s1[3] <= x[3]*x[8];
			p_s1[4] <= x[3]*x[7]; p_s1[5] <= x[4]*x[6];
			p_s1[6] <= x[2]*x[7]; p_s1[7] <= x[1]*x[8];
			p_s1[8] <= x[0]*x[8]; p_s1[9] <= x[2]*x[6];
			p_s1[10] <= x[1]*x[6]; p_s1[11] <= x[0]*x[7];
			p_s1[12] <= x[1]*x[5]; p_s1[13] <= x[2]*x[4];
			p_s1[14] <= x[2]*x[3]; p_s1[15] <= x[0]*x[5];
			p_s1[16] <= x[0]*x[4]; p_s1[17] <= x[1]*x[3];
			r0_s1 <= '{x[0], x[1], x[2]};
			for (int i = 0; i < 9; i++) c_s2[i] <= p_s1[2*i] - p_s1[2*i+1];
			r0_s2 <= r0_s1;
			// a*C as two 32-bit partial products: signed upper half, unsigned lower half
			for (int i = 0; i < 3; i++) begin
				ph_s3[i] <= r0_s2[i] * $signed(c_s2[i][CW-1:EW]);
				pl_s3[i] <= r0_s2[i] * $signed({1'b0, c_s2[i][EW-1:0]});
			end
			for (int i = 0; i < 9; i++) c_s3[i] <= c_s2[i];
			// recombined product fits the 97-bit sum exactly
			for (int i = 0; i < 3; i++)
				t_s4[i] <= (DW'(ph_s3[i]) <<< EW) + DW'(pl_s3[i]);
			c_s4 <= c_s3;
		end
	end

	assign out_vld = v_q[3];
	assign job.cof = c_s4;
	assign job.det = t_s4[0] + t_s4[1] + t_s4[2];
endmodule

### hdl/mi3_fifo.sv
module mi3_fifo import mi3_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	input  logic rd,
	output logic empty,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output job_t rdata
);
	localparam int unsigned AW = $clog2(DEPTH);
	job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
endmodule

### hdl/mi3_div.sv
// Pipelined restoring divider: one quotient bit per stage for nine lanes.
module mi3_div import mi3_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  job_t job,
	output logic out_vld,
	output mat_out_t res
);
	localparam int unsigned NS = QW;
	logic [NS:0] v_q;
	logic [MW-1:0] d_q [NS+1];
	logic [MW:0]   r_q [NS+1][9];
	logic [QW-1:0] q_q [NS+1][9];
	logic          n_q [NS+1][9];
	logic [QW-1:0] nb_q [NS+1][9];
	logic [63:0]   det_q [NS+1];
	logic          sing_q [NS+1];
	logic signed [DW-1:0] det;
	logic dneg;
	logic [DW-1:0] dmag;
	logic [CW-1:0] cm [9];
	logic [MW:0] rem0 [9];
	logic [63:0] dv;
	logic [DW-1:0] dsh;
	logic [EW-1:0] b [9];

	assign det  = job.det;
	assign dneg = det[DW-1];
	assign dmag = dneg ? DW'(-det) : DW'(det);
	assign dsh  = dmag >> 32;

	always_comb begin
		if (!dneg) dv = (dsh > DW'(64'h7FFF_FFFF_FFFF_FFFF)) ? 64'h7FFF_FFFF_FFFF_FFFF : dsh[63:0];
		else dv = (dsh > DW'(64'h8000_0000_0000_0000)) ? 64'h8000_0000_0000_0000
			: 64'(-dsh[63:0]);
		for (int i = 0; i < 9; i++) begin
			cm[i] = job.cof[i][CW-1] ? CW'(-job.cof[i]) : job.cof[i];
			// quotient bits above 2^33 always saturate; seed remainder with top of numerator
			rem0[i] = (MW+1)'({cm[i], 32'b0} >> QW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[NS-1:0], in_vld};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q[0] <= dmag[MW-1:0];
			det_q[0] <= dv;
			sing_q[0] <= (dmag == '0);
			for (int i = 0; i < 9; i++) begin
				r_q[0][i] <= rem0[i];
				q_q[0][i] <= '0;
				n_q[0][i] <= job.cof[i][CW-1] ^ dneg;
			end
			for (int s = 0; s < NS; s++) begin
				d_q[s+1] <= d_q[s];
				det_q[s+1] <= det_q[s];
				sing_q[s+1] <= sing_q[s];
				for (int i = 0; i < 9; i++) begin
					logic [MW+1:0] t;
					t = {r_q[s][i], nb_q[s][i][QW-1]};
					if (t >= {2'b0, d_q[s]}) begin
						r_q[s+1][i] <= (MW+1)'(t - {2'b0, d_q[s]});
						q_q[s+1][i] <= {q_q[s][i][QW-2:0], 1'b1};
					end else begin
						r_q[s+1][i] <= (MW+1)'(t);
						q_q[s+1][i] <= {q_q[s][i][QW-2:0], 1'b0};
					end
					n_q[s+1][i] <= n_q[s][i];
				end
			end
		end
	end

	// numerator bits for the low QW quotient positions travel with each lane
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				nb_q[0][i] <= QW'({cm[i], 32'b0});
				for (int s = 0; s < NS; s++) nb_q[s+1][i] <= {nb_q[s][i][QW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			logic [QW-1:0] q;
			q = q_q[NS][i];
			if (sing_q[NS]) b[i] = '0;
			else if (!n_q[NS][i]) b[i] = (q > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
			else b[i] = (q > QW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q[31:0]);
		end
	end

	assign out_vld = v_q[NS];
	// res[r][c] = cof[c][r] / det
	assign res.b00 = b[0]; assign res.b01 = b[3]; assign res.b02 = b[6];
	assign res.b10 = b[1]; assign res.b11 = b[4]; assign res.b12 = b[7];
	assign res.b20 = b[2]; assign res.b21 = b[5]; assign res.b22 = b[8];
	assign res.determinant = sing_q[NS] ? '0 : det_q[NS];
	assign res.singular = sing_q[NS];
endmodule
